// ===== sv/cpd_pkg.sv =====
// Shared types and constants for the compass direction projection block.
package cpd_pkg;

   localparam int unsigned SQRT_CELLS = 16;   // one root bit per cell
   localparam int unsigned DIV_CELLS  = 8;    // one quotient bit per cell

   localparam logic [15:0] NEAR_LIMIT     = 16'hb504;
   localparam logic [15:0] ZERO_LEN       = 16'hFFFF;
   localparam logic [7:0]  CENTRE_X_RESET = 8'd182;
   localparam logic [7:0]  CENTRE_Y_RESET = 8'd115;

   typedef enum logic {
      CSR_CENTRE_X = 1'b0,
      CSR_CENTRE_Y = 1'b1
   } csr_idx_type;

   // item travelling down the square root chain
   typedef struct packed {
      logic [31:0] rad;      // radicand bits still to be consumed, MSB first
      logic [16:0] rem;      // partial remainder
      logic [15:0] root;     // partial root
      logic [23:0] num_x;    // magnitude of the x numerator
      logic [23:0] num_y;
      logic        neg_x;
      logic        neg_y;
      logic        behind;
   } sq_bus_type;

   // one division lane
   typedef struct packed {
      logic [15:0] rem;      // partial remainder, below the divisor unless sat is set
      logic [7:0]  nlow;     // numerator bits still to be brought down
      logic [7:0]  quo;      // quotient bits so far
      logic        sat;      // quotient already known to be 256 or more
      logic        neg;      // sign of the numerator
   } div_lane_type;

   // item travelling down the division chain
   typedef struct packed {
      div_lane_type lx;
      div_lane_type ly;
      logic [15:0]  den;
      logic         behind;
   } div_bus_type;

endpackage

// ===== sv/cpd_front.sv =====
// Front end: coordinate reduction, squares, near/far choice and radicand select.
module cpd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [31:0]      pos_x,
   input  logic signed [31:0]      pos_y,
   input  logic signed [31:0]      pos_z,
   input  logic                    down_hold,
   output logic                    up_hold,
   output logic                    out_valid,
   output cpd_pkg::sq_bus_type     out_bus
);

   logic [31:0] raw [3];
   logic [23:0] red_mag [3];
   logic [15:0] far_mag [3];
   logic [2:0]  near_ok;

   // stage A registers
   logic        a_valid_ff;
   logic [31:0] near_sq_ff [3];
   logic [31:0] far_sq_ff [3];
   logic        all_near_ff;
   logic [23:0] mag_x_ff, mag_y_ff;
   logic        neg_x_ff, neg_y_ff, behind_ff;
   logic        a_hold;

   // stage B
   logic                 b_valid_ff;
   cpd_pkg::sq_bus_type  b_bus_ff, b_bus_in;
   logic                 b_hold;
   logic [33:0]          near_sum, far_sum;
   logic                 far;

   assign raw[0] = pos_x;
   assign raw[1] = pos_y;
   assign raw[2] = pos_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         red_mag[i] = raw[i][31] ? (~raw[i][31:8] + 24'd1) : raw[i][31:8];
         far_mag[i] = raw[i][31] ? (~raw[i][31:16] + 16'd1) : raw[i][31:16];
         near_ok[i] = (red_mag[i] <= {8'd0, cpd_pkg::NEAR_LIMIT});
      end
   end

   assign b_hold  = b_valid_ff && down_hold;
   assign a_hold  = a_valid_ff && b_hold;
   assign up_hold = a_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!a_hold) begin
         a_valid_ff <= in_valid;
      end
      if (!a_hold) begin
         for (int i = 0; i < 3; i++) begin
            near_sq_ff[i] <= 32'(red_mag[i][15:0]) * 32'(red_mag[i][15:0]);
            far_sq_ff[i]  <= 32'(far_mag[i]) * 32'(far_mag[i]);
         end
         all_near_ff <= &near_ok;
         mag_x_ff    <= red_mag[0];
         mag_y_ff    <= red_mag[1];
         neg_x_ff    <= raw[0][31];
         neg_y_ff    <= raw[1][31];
         behind_ff   <= raw[2][31];
      end
   end

   always_comb begin
      near_sum = {2'b00, near_sq_ff[0]} + {2'b00, near_sq_ff[1]} + {2'b00, near_sq_ff[2]};
      far_sum  = {2'b00, far_sq_ff[0]} + {2'b00, far_sq_ff[1]} + {2'b00, far_sq_ff[2]};
      // far when a magnitude is out of range or the sum reaches 2^31
      far      = !all_near_ff || (near_sum[33:31] != 3'd0);
      b_bus_in.rad    = far ? far_sum[31:0] : near_sum[31:0];
      b_bus_in.rem    = '0;
      b_bus_in.root   = '0;
      b_bus_in.num_x  = far ? mag_x_ff : {mag_x_ff[15:0], 8'h00};
      b_bus_in.num_y  = far ? mag_y_ff : {mag_y_ff[15:0], 8'h00};
      b_bus_in.neg_x  = neg_x_ff;
      b_bus_in.neg_y  = neg_y_ff;
      b_bus_in.behind = behind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!b_hold) begin
         b_valid_ff <= a_valid_ff;
      end
      if (!b_hold) begin
         b_bus_ff <= b_bus_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_bus   = b_bus_ff;

endmodule

// ===== sv/cpd_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per item.
module cpd_sqrt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  cpd_pkg::sq_bus_type  in_bus,
   input  logic                 down_hold,
   output logic                 up_hold,
   output logic                 out_valid,
   output cpd_pkg::sq_bus_type  out_bus
);

   logic                 valid_ff;
   cpd_pkg::sq_bus_type  bus_ff, bus_in;
   logic [18:0]          rs, trial;
   logic                 ge;

   always_comb begin
      rs     = {in_bus.rem, in_bus.rad[31:30]};
      trial  = {1'b0, in_bus.root, 2'b01};
      ge     = (rs >= trial);
      bus_in = in_bus;
      bus_in.rem  = ge ? 17'(rs - trial) : rs[16:0];
      bus_in.root = {in_bus.root[14:0], ge};
      bus_in.rad  = {in_bus.rad[29:0], 2'b00};
   end

   assign up_hold = valid_ff && down_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_hold) begin
         valid_ff <= in_valid;
      end
      if (!up_hold) begin
         bus_ff <= bus_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bus   = bus_ff;

endmodule

// ===== sv/cpd_div_cell.sv =====
// One cell of the division chain: one quotient bit for both lanes.
module cpd_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cpd_pkg::div_bus_type  in_bus,
   input  logic                  down_hold,
   output logic                  up_hold,
   output logic                  out_valid,
   output cpd_pkg::div_bus_type  out_bus
);

   function automatic cpd_pkg::div_lane_type lane_step(cpd_pkg::div_lane_type l,
                                                       logic [15:0] den);
      cpd_pkg::div_lane_type r;
      logic [16:0]           rs;
      logic                  ge;
      rs    = {l.rem, l.nlow[7]};
      ge    = (rs >= {1'b0, den});
      r     = l;
      r.rem  = ge ? 16'(rs - {1'b0, den}) : rs[15:0];
      r.quo  = {l.quo[6:0], ge};
      r.nlow = {l.nlow[6:0], 1'b0};
      return r;
   endfunction

   logic                  valid_ff;
   cpd_pkg::div_bus_type  bus_ff, bus_in;

   always_comb begin
      bus_in    = in_bus;
      bus_in.lx = lane_step(in_bus.lx, in_bus.den);
      bus_in.ly = lane_step(in_bus.ly, in_bus.den);
   end

   assign up_hold = valid_ff && down_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_hold) begin
         valid_ff <= in_valid;
      end
      if (!up_hold) begin
         bus_ff <= bus_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bus   = bus_ff;

endmodule

// ===== sv/compass_direction_projection.sv =====
// Top level of the compass direction projection block.
//
// Usage: a position item (req_pos_x/y/z) enters on the req_ valid/ready channel;
// one result item (rsp_spot_x, rsp_spot_y, rsp_behind) leaves on the rsp_
// channel for each one, in order. The dial centre sits in two registers on
// the csr_ port (centre_x at byte 0, centre_y at byte 4), written while idle.
//
// From acceptance to rsp_valid an item passes the front stages (squares,
// then sums and near/far choice), 16 square root cells at one root bit each,
// the divisor/saturation stage, 8 division cells at one quotient bit each for
// x and y side by side, and the output register. An item may enter every
// cycle while rsp_ready does not stall the chain, so throughput is one item per clock.
//
// Every stage has its own valid bit. A stall on rsp_ready holds only the
// occupied stages back to the first bubble, so req_ready stays high while
// the chain has any empty stage, also while a result waits at the output.
// Reset empties every stage and restores centre_x to 182, centre_y to 115.
module compass_direction_projection (
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [9:0]  rsp_spot_x,
   output logic signed [9:0]  rsp_spot_y,
   output logic               rsp_behind,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int unsigned NSQ  = cpd_pkg::SQRT_CELLS;
   localparam int unsigned NDIV = cpd_pkg::DIV_CELLS;

   // ---------------------------------------------------------------- registers
   logic [7:0] centre_x_ff, centre_y_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= cpd_pkg::CENTRE_X_RESET;
         centre_y_ff <= cpd_pkg::CENTRE_Y_RESET;
      end else if (csr_write) begin
         case (cpd_pkg::csr_idx_type'(csr_paddr[2]))
            cpd_pkg::CSR_CENTRE_X: centre_x_ff <= csr_pwdata[7:0];
            cpd_pkg::CSR_CENTRE_Y: centre_y_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cpd_pkg::csr_idx_type'(csr_paddr[2]))
         cpd_pkg::CSR_CENTRE_X: csr_prdata = {24'd0, centre_x_ff};
         cpd_pkg::CSR_CENTRE_Y: csr_prdata = {24'd0, centre_y_ff};
         default:               csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ front end
   cpd_pkg::sq_bus_type sq_bus  [NSQ+1];
   logic                sq_valid[NSQ+1];
   logic                sq_hold [NSQ+1];
   logic                front_hold;

   cpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .down_hold (sq_hold[0]),
      .up_hold   (front_hold),
      .out_valid (sq_valid[0]),
      .out_bus   (sq_bus[0])
   );

   assign req_ready = !front_hold;

   // ------------------------------------------------------ square root chain
   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      cpd_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_bus    (sq_bus[k]),
         .down_hold (sq_hold[k+1]),
         .up_hold   (sq_hold[k]),
         .out_valid (sq_valid[k+1]),
         .out_bus   (sq_bus[k+1])
      );
   end

   // ---------------------------------------- divisor and saturation stage
   cpd_pkg::div_bus_type dv_bus  [NDIV+1];
   logic                 dv_valid[NDIV+1];
   logic                 dv_hold [NDIV+1];

   cpd_pkg::div_bus_type sat_bus_ff, sat_bus_in;
   logic                 sat_valid_ff;
   logic [15:0]          den;

   always_comb begin
      // a zero length stands for the largest divisor
      den = (sq_bus[NSQ].root == 16'd0) ? cpd_pkg::ZERO_LEN : sq_bus[NSQ].root;
      sat_bus_in.den    = den;
      sat_bus_in.behind = sq_bus[NSQ].behind;
      // quotient of 256 or more already pins the offset, so 8 bits suffice
      sat_bus_in.lx.sat  = (sq_bus[NSQ].num_x >= {den, 8'h00});
      sat_bus_in.lx.rem  = sq_bus[NSQ].num_x[23:8];
      sat_bus_in.lx.nlow = sq_bus[NSQ].num_x[7:0];
      sat_bus_in.lx.quo  = '0;
      sat_bus_in.lx.neg  = sq_bus[NSQ].neg_x;
      sat_bus_in.ly.sat  = (sq_bus[NSQ].num_y >= {den, 8'h00});
      sat_bus_in.ly.rem  = sq_bus[NSQ].num_y[23:8];
      sat_bus_in.ly.nlow = sq_bus[NSQ].num_y[7:0];
      sat_bus_in.ly.quo  = '0;
      sat_bus_in.ly.neg  = sq_bus[NSQ].neg_y;
   end

   assign sq_hold[NSQ] = sat_valid_ff && dv_hold[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_valid_ff <= 1'b0;
      end else if (!sq_hold[NSQ]) begin
         sat_valid_ff <= sq_valid[NSQ];
      end
      if (!sq_hold[NSQ]) begin
         sat_bus_ff <= sat_bus_in;
      end
   end

   assign dv_valid[0] = sat_valid_ff;
   assign dv_bus[0]   = sat_bus_ff;

   // --------------------------------------------------------- division chain
   for (genvar k = 0; k < NDIV; k++) begin : g_div
      cpd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_bus    (dv_bus[k]),
         .down_hold (dv_hold[k+1]),
         .up_hold   (dv_hold[k]),
         .out_valid (dv_valid[k+1]),
         .out_bus   (dv_bus[k+1])
      );
   end

   // ----------------------------------------------------------- output stage
   // truncated quotient -> signed p -> floor((floor(p/16)+1)/2), clamped to +-8
   function automatic logic signed [4:0] dot_offset(cpd_pkg::div_lane_type l);
      logic [8:0]        q;
      logic signed [9:0] p;
      logic signed [9:0] f;
      logic signed [9:0] c;
      q = l.sat ? 9'd256 : {1'b0, l.quo};
      p = l.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      f = (p >>> 4) + 10'sd1;
      c = f >>> 1;
      if (c > 10'sd8) begin
         c = 10'sd8;
      end else if (c < -10'sd8) begin
         c = -10'sd8;
      end
      return c[4:0];
   endfunction

   logic signed [4:0] off_x, off_y;
   logic              out_valid_ff;
   logic signed [9:0] spot_x_ff, spot_y_ff;
   logic              behind_ff;

   assign off_x = dot_offset(dv_bus[NDIV].lx);
   assign off_y = dot_offset(dv_bus[NDIV].ly);

   assign dv_hold[NDIV] = out_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!dv_hold[NDIV]) begin
         out_valid_ff <= dv_valid[NDIV];
      end
      if (!dv_hold[NDIV]) begin
         spot_x_ff <= $signed({2'b00, centre_x_ff}) + {{5{off_x[4]}}, off_x};
         spot_y_ff <= $signed({2'b00, centre_y_ff}) - {{5{off_y[4]}}, off_y};
         behind_ff <= dv_bus[NDIV].behind;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_spot_x = spot_x_ff;
   assign rsp_spot_y = spot_y_ff;
   assign rsp_behind = behind_ff;

endmodule
